[hdl/csq_pkg.sv]
package csq_pkg;

    localparam int COUNT_W    = 16;
    localparam int INIT_W     = 15;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNAL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRYWAIT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 3'd4;

    localparam logic [APB_ADDR_W-3:0] REG_INITIAL_COUNT = '0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BLOCKED     = 3'd1,
        ST_CLOSED      = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_TIMED_OUT   = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_RELEASED    = 3'd6,
        ST_OVERFLOW    = 3'd7
    } t_status;

    typedef struct packed {
        t_status status;
        logic    woke;
        logic    last;
    } t_res_flags;

endpackage

[hdl/counting_semaphore_with_wait_queue.sv]
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_mode, i_thread_id
// output    o_out_valid / i_out_ready    o_status, o_target_thread, o_woke, o_last
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Wait, trywait and a plain signal go straight to the emit step; a signal that
// wakes a waiter reads the queue head. Close releases each queued waiter; timeout
// searches the queue, moving later entries down. RAM reads are registered.
// Synchronous active-low reset; the count clears to zero, the queue empties.
// A stalled output holds the control in its emit step; one result waits in the
// output register while the next transaction is accepted.
module counting_semaphore_with_wait_queue #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [csq_pkg::MODE_W-1:0]          i_mode,
    input  logic [THREAD_ID_BITS-1:0]           i_thread_id,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [csq_pkg::STATUS_W-1:0]        o_status,
    output logic [THREAD_ID_BITS-1:0]           o_target_thread,
    output logic                                o_woke,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csq_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [csq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [csq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import csq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [INIT_W-1:0] r_initial_count;
    logic c_cfg_load;
    logic c_sel_init;

    logic res_valid;
    logic res_ready;
    t_res_flags res_flags;
    logic [THREAD_ID_BITS-1:0] res_tid;
    t_res_flags out_flags;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [THREAD_ID_BITS-1:0] wr_data;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic [THREAD_ID_BITS-1:0] rd_data;

    assign pready     = 1'b1;
    assign c_sel_init = paddr[APB_ADDR_W-1:2] == REG_INITIAL_COUNT;
    assign c_cfg_load = psel && penable && pwrite && pready && c_sel_init;
    assign prdata     = c_sel_init ? APB_DATA_W'(r_initial_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_count <= '0;
        end else if (c_cfg_load) begin
            r_initial_count <= pwdata[INIT_W-1:0];
        end
    end

    csq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TID_W       (THREAD_ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_thread_id (i_thread_id),
        .i_cfg_load  (c_cfg_load),
        .i_cfg_value (pwdata[INIT_W-1:0]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_flags (res_flags),
        .o_res_tid   (res_tid),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    csq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (THREAD_ID_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    csq_out #(
        .TID_W (THREAD_ID_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res_flags (res_flags),
        .i_res_tid   (res_tid),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_flags (out_flags),
        .o_out_tid   (o_target_thread)
    );

    assign o_status = out_flags.status;
    assign o_woke   = out_flags.woke;
    assign o_last   = out_flags.last;

endmodule

[hdl/csq_mem.sv]
module csq_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/csq_out.sv]
module csq_out #(
    parameter int TID_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    output logic                 o_res_ready,
    input  csq_pkg::t_res_flags  i_res_flags,
    input  logic [TID_W-1:0]     i_res_tid,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output csq_pkg::t_res_flags  o_out_flags,
    output logic [TID_W-1:0]     o_out_tid
);

    import csq_pkg::*;

    logic       r_valid;
    t_res_flags r_flags;
    logic [TID_W-1:0] r_tid;

    assign o_res_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
        if (i_res_valid && o_res_ready) begin
            r_flags <= i_res_flags;
            r_tid   <= i_res_tid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_flags = r_flags;
    assign o_out_tid   = r_tid;

endmodule

[hdl/csq_ctrl.sv]
module csq_ctrl #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TID_W       = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [csq_pkg::MODE_W-1:0]     i_mode,
    input  logic [TID_W-1:0]               i_thread_id,
    input  logic                           i_cfg_load,
    input  logic [csq_pkg::INIT_W-1:0]     i_cfg_value,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output csq_pkg::t_res_flags            o_res_flags,
    output logic [TID_W-1:0]               o_res_tid,
    output logic                           o_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_wr_addr,
    output logic [TID_W-1:0]               o_wr_data,
    output logic                           o_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_addr,
    input  logic [TID_W-1:0]               i_rd_data
);

    import csq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAKE,
        S_CLS_RD,
        S_CLS_DATA,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state r_ret;
    logic signed [COUNT_W-1:0] r_count;
    logic r_open;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_idx;
    logic [TID_W-1:0] r_tid;
    t_res_flags r_res_flags;
    logic [TID_W-1:0] r_res_tid;

    logic c_le0;
    logic c_min;
    logic c_max;
    logic c_full;
    logic c_start;
    logic c_wake;
    logic c_enq;
    logic [FW-1:0] c_idx_inc;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [FW-1:0] off);
        logic [FW:0] s;
        s = (FW+1)'(head) + (FW+1)'(off);
        if (s >= (FW+1)'(QUEUE_DEPTH)) begin
            s = s - (FW+1)'(QUEUE_DEPTH);
        end
        return AW'(s);
    endfunction

    assign c_le0     = r_count <= 16'sd0;
    assign c_min     = r_count == COUNT_MIN;
    assign c_max     = r_count == COUNT_MAX;
    assign c_full    = r_fill == FILL_FULL;
    assign c_idx_inc = r_idx + FW'(1);
    assign c_start   = (r_state == S_IDLE) && i_in_valid && r_open;
    assign c_wake    = c_start && (i_mode == MODE_SIGNAL) && (r_count < 16'sd0)
                       && (r_fill != '0);
    assign c_enq     = c_start && (i_mode == MODE_WAIT) && c_le0 && !c_full && !c_min;

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_head;
        o_wr_en   = 1'b0;
        o_wr_addr = f_slot(r_head, r_idx);
        o_wr_data = i_rd_data;
        case (r_state)
            S_IDLE: begin
                o_rd_en   = c_wake;
                o_wr_en   = c_enq;
                o_wr_addr = f_slot(r_head, r_fill);
                o_wr_data = i_thread_id;
            end
            S_CLS_RD, S_SRCH_RD: begin
                o_rd_en   = r_idx != r_fill;
                o_rd_addr = f_slot(r_head, r_idx);
            end
            S_SHIFT_RD: begin
                o_rd_en   = c_idx_inc != r_fill;
                o_rd_addr = f_slot(r_head, c_idx_inc);
            end
            S_SHIFT_WR: begin
                o_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_count <= '0;
            r_open  <= 1'b1;
            r_head  <= '0;
            r_fill  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tid       <= i_thread_id;
                        r_idx       <= '0;
                        r_ret       <= S_IDLE;
                        r_res_tid   <= i_thread_id;
                        r_res_flags <= '{status: ST_OK, woke: 1'b0, last: 1'b1};
                        if (!(i_mode inside {[MODE_WAIT:MODE_TIMEOUT]})) begin
                            r_state <= S_IDLE;
                        end else if (!r_open) begin
                            r_res_flags.status <= ST_CLOSED;
                            r_state <= S_EMIT;
                        end else begin
                            case (i_mode)
                                MODE_WAIT: begin
                                    r_state <= S_EMIT;
                                    if (c_le0 && (c_full || c_min)) begin
                                        r_res_flags.status <= ST_OVERFLOW;
                                    end else begin
                                        r_count <= r_count - 16'sd1;
                                        if (c_le0) begin
                                            r_fill <= r_fill + FW'(1);
                                            r_res_flags.status <= ST_BLOCKED;
                                        end
                                    end
                                end
                                MODE_SIGNAL: begin
                                    r_state <= S_EMIT;
                                    if (c_max) begin
                                        r_res_flags.status <= ST_OVERFLOW;
                                    end else begin
                                        r_count <= r_count + 16'sd1;
                                        if (c_wake) begin
                                            r_state <= S_WAKE;
                                        end
                                    end
                                end
                                MODE_TRYWAIT: begin
                                    r_state <= S_EMIT;
                                    if (c_le0) begin
                                        r_res_flags.status <= ST_WOULD_BLOCK;
                                    end else begin
                                        r_count <= r_count - 16'sd1;
                                    end
                                end
                                MODE_CLOSE: begin
                                    r_state <= S_CLS_RD;
                                end
                                default: begin
                                    r_state <= S_SRCH_RD;
                                end
                            endcase
                        end
                    end
                end
                S_WAKE: begin
                    r_res_tid        <= i_rd_data;
                    r_res_flags.woke <= 1'b1;
                    r_head  <= (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                    r_fill  <= r_fill - FW'(1);
                    r_state <= S_EMIT;
                end
                S_CLS_RD: begin
                    if (r_idx == r_fill) begin
                        r_head      <= '0;
                        r_fill      <= '0;
                        r_open      <= 1'b0;
                        r_res_tid   <= r_tid;
                        r_res_flags <= '{status: ST_OK, woke: 1'b0, last: 1'b1};
                        r_ret       <= S_IDLE;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_CLS_DATA;
                    end
                end
                S_CLS_DATA: begin
                    r_res_tid   <= i_rd_data;
                    r_res_flags <= '{status: ST_RELEASED, woke: 1'b1, last: 1'b0};
                    r_idx       <= c_idx_inc;
                    r_ret       <= S_CLS_RD;
                    r_state     <= S_EMIT;
                end
                S_SRCH_RD: begin
                    if (r_idx == r_fill) begin
                        r_res_flags <= '{status: ST_NOT_FOUND, woke: 1'b0, last: 1'b1};
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (i_rd_data == r_tid) begin
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_idx   <= c_idx_inc;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (c_idx_inc == r_fill) begin
                        r_fill <= r_fill - FW'(1);
                        if (!c_max) begin
                            r_count <= r_count + 16'sd1;
                        end
                        r_res_flags <= '{status: ST_TIMED_OUT, woke: 1'b1, last: 1'b1};
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= c_idx_inc;
                    r_state <= S_SHIFT_RD;
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_load) begin
                r_count <= COUNT_W'({1'b0, i_cfg_value});
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_res_valid = r_state == S_EMIT;
    assign o_res_flags = r_res_flags;
    assign o_res_tid   = r_res_tid;

endmodule

[dv/tb_counting_semaphore_with_wait_queue.sv]
module tb_counting_semaphore_with_wait_queue;
    import csq_pkg::*;

    localparam int QDEPTH        = 32;
    localparam int TID_W         = 8;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_CAP     = 100;

    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    typedef struct {
        t_status          status;
        logic [TID_W-1:0] target;
        logic             woke;
        logic             last;
    } sem_result_t;

    class semaphore_tracker;
        int               level;
        bit               is_open;
        logic [TID_W-1:0] waiters[$];
        sem_result_t      expected[$];
        int               n_errors;

        function new();
            level    = 0;
            is_open  = 1'b1;
            n_errors = 0;
        endfunction

        task report(input string what);
            if (n_errors < PRINT_CAP) $display("ERROR: %s", what);
            n_errors++;
        endtask

        function void load_count(input logic [INIT_W-1:0] value);
            level = int'(value);
        endfunction

        function int outstanding();
            return expected.size();
        endfunction

        function void push_result(input t_status st, input logic [TID_W-1:0] tgt,
                                  input logic wk, input logic lst);
            sem_result_t r;
            r.status = st;
            r.target = tgt;
            r.woke   = wk;
            r.last   = lst;
            expected.push_back(r);
        endfunction

        function void note_call(input logic [MODE_W-1:0] mode, input logic [TID_W-1:0] tid);
            int               idx;
            logic [TID_W-1:0] w;
            if (mode > MODE_TIMEOUT) return;
            if (!is_open) begin
                push_result(ST_CLOSED, tid, 1'b0, 1'b1);
                return;
            end
            case (mode)
                MODE_WAIT: begin
                    if (level <= 0 && (waiters.size() >= QDEPTH || level <= int'(COUNT_MIN))) begin
                        push_result(ST_OVERFLOW, tid, 1'b0, 1'b1);
                    end else begin
                        level--;
                        if (level < 0) begin
                            waiters.push_back(tid);
                            push_result(ST_BLOCKED, tid, 1'b0, 1'b1);
                        end else begin
                            push_result(ST_OK, tid, 1'b0, 1'b1);
                        end
                    end
                end
                MODE_SIGNAL: begin
                    if (level >= int'(COUNT_MAX)) begin
                        push_result(ST_OVERFLOW, tid, 1'b0, 1'b1);
                    end else begin
                        level++;
                        if (level <= 0 && waiters.size() > 0) begin
                            w = waiters.pop_front();
                            push_result(ST_OK, w, 1'b1, 1'b1);
                        end else begin
                            push_result(ST_OK, tid, 1'b0, 1'b1);
                        end
                    end
                end
                MODE_TRYWAIT: begin
                    if (level <= 0) begin
                        push_result(ST_WOULD_BLOCK, tid, 1'b0, 1'b1);
                    end else begin
                        level--;
                        push_result(ST_OK, tid, 1'b0, 1'b1);
                    end
                end
                MODE_CLOSE: begin
                    foreach (waiters[i]) push_result(ST_RELEASED, waiters[i], 1'b1, 1'b0);
                    waiters.delete();
                    is_open = 1'b0;
                    push_result(ST_OK, tid, 1'b0, 1'b1);
                end
                default: begin
                    idx = -1;
                    foreach (waiters[i]) begin
                        if (idx < 0 && waiters[i] == tid) idx = i;
                    end
                    if (idx < 0) begin
                        push_result(ST_NOT_FOUND, tid, 1'b0, 1'b1);
                    end else begin
                        waiters.delete(idx);
                        if (level < int'(COUNT_MAX)) level++;
                        push_result(ST_TIMED_OUT, tid, 1'b1, 1'b1);
                    end
                end
            endcase
        endfunction

        task check_result(input logic [STATUS_W-1:0] st, input logic [TID_W-1:0] tgt,
                          input logic wk, input logic lst);
            sem_result_t r;
            if (expected.size() == 0) begin
                report($sformatf("unexpected result status %0d thread %0h", st, tgt));
                return;
            end
            r = expected.pop_front();
            if (st !== r.status)
                report($sformatf("status %0d, want %0d (thread %0h)", st, r.status, r.target));
            if (tgt !== r.target)
                report($sformatf("target_thread %0h, want %0h", tgt, r.target));
            if (wk !== r.woke)
                report($sformatf("woke %0b, want %0b (thread %0h)", wk, r.woke, r.target));
            if (lst !== r.last)
                report($sformatf("last %0b, want %0b (thread %0h)", lst, r.last, r.target));
        endtask

        task finish_check();
            if (expected.size() != 0)
                report($sformatf("%0d expected results never arrived", expected.size()));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [MODE_W-1:0]     i_mode;
    logic [TID_W-1:0]      i_thread_id;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [TID_W-1:0]      o_target_thread;
    logic                  o_woke;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    semaphore_tracker sem;
    int               burst_left    = 0;
    int               hold_requests = 0;
    int               cycles        = 0;

    counting_semaphore_with_wait_queue #(
        .QUEUE_DEPTH   (QDEPTH),
        .THREAD_ID_BITS(TID_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_thread_id    (i_thread_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_target_thread(o_target_thread),
        .o_woke         (o_woke),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sem.note_call(i_mode, i_thread_id);
            if (o_out_valid && i_out_ready)
                sem.check_result(o_status, o_target_thread, o_woke, o_last);
        end
    end

    // receiver: changing stall styles, plus long hold-offs on request
    initial begin
        int hold_done;
        int span;
        int style;
        hold_done = 0;
        span      = 0;
        style     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_requests) begin
                hold_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    span  = $urandom_range(20, 200);
                    style = $urandom_range(0, 3);
                end
                span--;
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    task automatic offer(input logic [MODE_W-1:0] m, input logic [TID_W-1:0] t);
        i_in_valid  <= 1'b1;
        i_mode      <= m;
        i_thread_id <= t;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        while (sem.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_initial_count(input logic [INIT_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INITIAL_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sem.load_count(value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(input int w_wait, input int w_sig,
                                                    input int w_try, input int w_to);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_wait) return MODE_WAIT;
        if (r < w_wait + w_sig) return MODE_SIGNAL;
        if (r < w_wait + w_sig + w_try) return MODE_TRYWAIT;
        if (r < w_wait + w_sig + w_try + w_to) return MODE_TIMEOUT;
        return MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    endfunction

    task automatic run_calls(input int n, input int w_wait, input int w_sig,
                             input int w_try, input int w_to);
        int               counted;
        logic [MODE_W-1:0] m;
        logic [TID_W-1:0]  t;
        counted = 0;
        while (counted < n) begin
            m = pick_mode(w_wait, w_sig, w_try, w_to);
            t = TID_W'($urandom);
            if (m == MODE_TIMEOUT && sem.waiters.size() > 0 && $urandom_range(0, 3) != 0)
                t = sem.waiters[$urandom_range(0, sem.waiters.size() - 1)];
            pace();
            offer(m, t);
            if (m <= MODE_TIMEOUT) counted++;
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic fill_waiters(input int extra);
        int need;
        need = QDEPTH - sem.waiters.size() + extra;
        repeat (need) begin
            pace();
            offer(MODE_WAIT, TID_W'($urandom));
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        sem         = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_WAIT;
        i_thread_id = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of zero: blocking, waking, timeouts, ignored codes
        offer(MODE_TRYWAIT, 8'h00);
        offer(MODE_SIGNAL,  8'hFF);
        offer(MODE_TRYWAIT, 8'hAA);
        offer(MODE_WAIT,    8'h55);
        offer(MODE_WAIT,    8'h00);
        offer(MODE_WAIT,    8'hFF);
        offer(MODE_TIMEOUT, 8'h00);
        offer(MODE_TIMEOUT, 8'h12);
        offer(MODE_SIGNAL,  8'h01);
        offer(MODE_RSVD5,   8'h33);
        offer(MODE_RSVD6,   8'hCC);
        offer(MODE_RSVD7,   8'h0F);
        offer(MODE_WAIT,    8'h80);
        offer(MODE_WAIT,    8'h80);
        offer(MODE_TIMEOUT, 8'h80);
        offer(MODE_SIGNAL,  8'h7F);
        offer(MODE_SIGNAL,  8'h7F);
        offer(MODE_SIGNAL,  8'hFE);
        i_in_valid <= 1'b0;

        // full queue, then count at its maximum with waiters still queued
        write_initial_count('0);
        fill_waiters(2);
        write_initial_count(INIT_W'(int'(COUNT_MAX)));
        offer(MODE_TIMEOUT, sem.waiters[$urandom_range(0, sem.waiters.size() - 1)]);
        offer(MODE_SIGNAL,  8'h01);
        offer(MODE_WAIT,    8'h02);
        offer(MODE_SIGNAL,  8'h03);
        offer(MODE_SIGNAL,  8'h04);
        i_in_valid <= 1'b0;

        write_initial_count('0);
        run_calls(90, 35, 35, 12, 15);
        write_initial_count(INIT_W'(3));
        run_calls(90, 55, 20, 10, 12);

        // hold the output while items keep coming
        write_initial_count('0);
        hold_requests = hold_requests + 1;
        burst_left    = 60;
        run_calls(90, 40, 35, 10, 12);

        write_initial_count(INIT_W'(int'(COUNT_MAX)));
        run_calls(90, 20, 55, 10, 12);
        write_initial_count(INIT_W'($urandom_range(1, int'(COUNT_MAX) - 1)));
        run_calls(90, 30, 40, 15, 12);

        // close with a full queue, then every code on the closed semaphore
        write_initial_count('0);
        fill_waiters(1);
        settle();
        offer(MODE_CLOSE, TID_W'($urandom));
        for (int m = 0; m < 8; m++) begin
            pace();
            offer(MODE_W'(m), TID_W'($urandom));
        end
        i_in_valid <= 1'b0;

        settle();
        sem.finish_check();
        if (sem.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[counting_semaphore_with_wait_queue.f]
hdl/csq_pkg.sv
hdl/csq_mem.sv
hdl/csq_out.sv
hdl/csq_ctrl.sv
hdl/counting_semaphore_with_wait_queue.sv
dv/tb_counting_semaphore_with_wait_queue.sv
